[src/gray_gradient_edge_threshold_defines.svh]
// Assertion macros shared by the checker of the gray gradient edge block.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef GRAY_GRADIENT_EDGE_THRESHOLD_DEFINES_SVH
`define GRAY_GRADIENT_EDGE_THRESHOLD_DEFINES_SVH

// Same-cycle implication, switched off while reset is low.
`define GGEDGE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ggedge check failed");

// Next-cycle implication, switched off while reset is low.
`define GGEDGE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ggedge check failed");

// Checks what a low reset leaves behind in the next cycle.
`define GGEDGE_ASSERT_RESET(name, clk, rst_n, cons) \
    name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("ggedge reset check failed");

`endif

[src/ggedge_pkg.sv]
// Package of the gray gradient edge block: sizes, gray weights, register codes,
// the structs passed between the top level and the line store. Depends on nothing.
package ggedge_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Gray conversion: floor(sum / 100) computed as (sum * 5243) >> 19, exact
    // for every sum below 25600.
    localparam int SUM_W      = 15;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0]   W_RED       = SUM_W'(30);
    localparam logic [SUM_W-1:0]   W_GREEN     = SUM_W'(59);
    localparam logic [SUM_W-1:0]   W_BLUE      = SUM_W'(11);
    localparam logic [RECIP_W-1:0] GRAY_RECIP  = RECIP_W'(5243);
    localparam int                 GRAY_SHIFT  = 19;

    // Gradient magnitude: dx^2 + dy^2 scaled by 64 against T^2.
    localparam int SQ_W      = 2 * PIX_W;
    localparam int MAG_W     = SQ_W + 1;
    localparam int MAG_SHIFT = 6;
    localparam int MAGX_W    = MAG_W + MAG_SHIFT;
    localparam int TSQ_W     = 2 * CFG_W;

    localparam logic [PIX_W-1:0] LEVEL_BLACK = '0;
    localparam logic [PIX_W-1:0] LEVEL_WHITE = '1;

    // Register codes (byte address / 4).
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_IMAGE_WIDTH    = 2'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT   = 2'd1;
    localparam t_reg_idx REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = CFG_W'(480);
    localparam logic [CFG_W-1:0] RST_EDGE_THRESHOLD = CFG_W'(160);

    typedef struct packed {
        logic has_above;   // a pixel one row up is emitted by this input
        logic interior;    // that pixel is thresholded
        logic last_row;
        logic last_col;
    } t_flags;

    typedef struct packed {
        logic [COL_W-1:0] col;
        t_flags           flags;
    } t_pos;

    typedef struct packed {
        logic signed [PIX_W:0] dx;
        logic signed [PIX_W:0] dy;
        logic [PIX_W-1:0]      up;
        logic [PIX_W-1:0]      gray;
        t_flags                flags;
    } t_grad;

    // Index of the last column for a written width, with 0 read as 1 and
    // anything above the maximum read as the maximum.
    function automatic logic [COL_W-1:0] col_last(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH - 1);
        end else begin
            return COL_W'(v - 1'b1);
        end
    endfunction

    function automatic logic [ROW_W-1:0] row_last(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end else begin
            return ROW_W'(v - 1'b1);
        end
    endfunction

endpackage

[src/ggedge_line.sv]
// Line stores of the gray gradient edge block: two rows of gray values, the
// prefetch of the neighbors and the central differences. Depends on ggedge_pkg.
module ggedge_line (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ggedge_pkg::PIX_W-1:0] i_gray,
    input  ggedge_pkg::t_pos            i_pos,
    output ggedge_pkg::t_grad           o_grad
);

    logic [ggedge_pkg::PIX_W-1:0] r_line1 [ggedge_pkg::MAX_WIDTH];
    logic [ggedge_pkg::PIX_W-1:0] r_line2 [ggedge_pkg::MAX_WIDTH];

    logic [ggedge_pkg::PIX_W-1:0] r_pl_rd;
    logic [ggedge_pkg::PIX_W-1:0] r_p2_rd;
    logic [ggedge_pkg::PIX_W-1:0] r_up;
    logic [ggedge_pkg::PIX_W-1:0] r_up_left;
    logic [ggedge_pkg::PIX_W-1:0] r_first0;
    logic [ggedge_pkg::PIX_W-1:0] r_first1;
    logic                         r_wrap;
    ggedge_pkg::t_grad            r_grad;

    logic [ggedge_pkg::PIX_W-1:0] w_right;
    logic [ggedge_pkg::PIX_W-1:0] n_first0;
    logic [ggedge_pkg::PIX_W-1:0] n_first1;
    logic [ggedge_pkg::COL_W-1:0] w_rd1_addr;
    logic [ggedge_pkg::COL_W-1:0] w_rd2_addr;

    // After a row wrap the right neighbor of column 0 is column 1 of the row
    // just written, held in a register; otherwise it comes from the prefetch.
    assign w_right    = r_wrap ? r_first1 : r_pl_rd;
    assign n_first0   = (i_pos.col == ggedge_pkg::COL_W'(0)) ? i_gray : r_first0;
    assign n_first1   = (i_pos.col == ggedge_pkg::COL_W'(1)) ? i_gray : r_first1;
    assign w_rd1_addr = i_pos.col + ggedge_pkg::COL_W'(2);
    assign w_rd2_addr = i_pos.flags.last_col ? '0 : i_pos.col + ggedge_pkg::COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_line1[i_pos.col] <= i_gray;
            r_line2[i_pos.col] <= r_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pl_rd <= r_line1[w_rd1_addr];
            // A one-column row reads back the entry it writes in this cycle.
            if (w_rd2_addr == i_pos.col) begin
                r_p2_rd <= r_up;
            end else begin
                r_p2_rd <= r_line2[w_rd2_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= 1'b0;
        end else if (i_load) begin
            r_wrap <= i_pos.flags.last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_first0 <= n_first0;
            r_first1 <= n_first1;
            r_up     <= i_pos.flags.last_col ? n_first0 : w_right;
            if (i_pos.flags.has_above) begin
                r_up_left <= r_up;
            end
            r_grad.dx    <= $signed({1'b0, w_right}) - $signed({1'b0, r_up_left});
            r_grad.dy    <= $signed({1'b0, i_gray}) - $signed({1'b0, r_p2_rd});
            r_grad.up    <= r_up;
            r_grad.gray  <= i_gray;
            r_grad.flags <= i_pos.flags;
        end
    end

    assign o_grad = r_grad;

endmodule

[src/gray_gradient_edge_threshold.sv]
// Top level of the gray gradient edge block: stream ports, register port,
// gray conversion, gradient threshold and result sequencing.
// Depends on ggedge_pkg and ggedge_line.

// Takes RGB pixels in raster order and emits one row later a gray or
// thresholded image. Each pixel becomes gray = floor((30r + 59g + 11b) / 100).
// An interior pixel is black when 64*(dx^2 + dy^2) exceeds T^2 (T is
// edge_threshold in eighths of a gray step) and white otherwise, with dx and
// dy the central differences; border pixels carry their gray value. The pixel
// one row up is emitted for every input of rows 1 and later, and each input of
// the last row is also emitted itself, so the last row yields two results per
// request unless it is also the first. A new request is taken on every clock
// while the output keeps up: one pixel per clock in all rows but the last; in
// the last row the single result port is the limit and holds the pipeline until
// both results of a pixel are taken. The first result of a request passes the
// weighted sum, gray, line store and magnitude registers and is presented from
// the result register. The two 2048-entry by 8-bit line stores each have one
// write and one read per pixel; they need no clearing pass, since no result of
// the first row of a frame depends on them. Writing image_width or image_height
// starts a new frame; edge_threshold takes effect on the next pixel. The user
// must write registers only while the block is idle; it is not enforced.
module gray_gradient_edge_threshold (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel requests.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [23:0]                       i_s_axis_tdata,  // red, green, blue
    // Results.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // level
    output logic [1:0]                        o_m_axis_tuser,  // is_interior, frame_done
    output logic                              o_m_axis_tlast,  // last_in_run
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ggedge_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ggedge_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ggedge_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);

    // Configuration and position.
    logic [ggedge_pkg::CFG_W-1:0] r_cfg_width;
    logic [ggedge_pkg::CFG_W-1:0] r_cfg_height;
    logic [ggedge_pkg::CFG_W-1:0] r_cfg_thresh;
    logic [ggedge_pkg::COL_W-1:0] r_w_last;
    logic [ggedge_pkg::ROW_W-1:0] r_h_last;
    logic [ggedge_pkg::COL_W-1:0] r_col;
    logic [ggedge_pkg::ROW_W-1:0] r_row;
    logic [ggedge_pkg::TSQ_W-1:0] r_tsq;

    logic [ggedge_pkg::COL_W-1:0] n_col;
    logic [ggedge_pkg::ROW_W-1:0] n_row;
    ggedge_pkg::t_pos             w_pos;
    ggedge_pkg::t_reg_idx         w_reg_idx;
    logic                         w_cfg_wr;
    logic [ggedge_pkg::CFG_W-1:0] w_cfg_val;

    // Pipeline: 1 weighted sum, 2 gray, 3 line store, 4 magnitude, 5 result.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_in_acc;

    logic [ggedge_pkg::SUM_W-1:0]  r_sum1;
    ggedge_pkg::t_pos              r_pos1;
    logic [ggedge_pkg::SUM_W-1:0]  w_sum;
    logic [ggedge_pkg::PROD_W-1:0] w_prod;

    logic [ggedge_pkg::PIX_W-1:0]  r_gray2;
    ggedge_pkg::t_pos              r_pos2;

    ggedge_pkg::t_grad             w_grad3;

    logic signed [2*ggedge_pkg::PIX_W+1:0] w_dx_sq;
    logic signed [2*ggedge_pkg::PIX_W+1:0] w_dy_sq;
    logic [ggedge_pkg::MAG_W-1:0]  r_mag4;
    logic [ggedge_pkg::PIX_W-1:0]  r_up4;
    logic [ggedge_pkg::PIX_W-1:0]  r_gray4;
    ggedge_pkg::t_flags            r_flags4;
    logic                          w_edge4;
    logic [ggedge_pkg::PIX_W-1:0]  w_level_a4;

    logic                          r_sel5;
    logic [ggedge_pkg::PIX_W-1:0]  r_a_level5;
    logic                          r_a_int5;
    logic [ggedge_pkg::PIX_W-1:0]  r_b_level5;
    logic                          r_b_valid5;
    logic                          r_last_col5;

    // ---------------------------------------------------------------- registers
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ggedge_pkg::APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_val = pwdata[ggedge_pkg::CFG_W-1:0];

    always_comb begin
        case (w_reg_idx)
            ggedge_pkg::REG_IMAGE_WIDTH: begin
                prdata = {{(ggedge_pkg::APB_DATA_W-ggedge_pkg::CFG_W){1'b0}}, r_cfg_width};
            end
            ggedge_pkg::REG_IMAGE_HEIGHT: begin
                prdata = {{(ggedge_pkg::APB_DATA_W-ggedge_pkg::CFG_W){1'b0}}, r_cfg_height};
            end
            ggedge_pkg::REG_EDGE_THRESHOLD: begin
                prdata = {{(ggedge_pkg::APB_DATA_W-ggedge_pkg::CFG_W){1'b0}}, r_cfg_thresh};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Square of the threshold, refreshed every cycle from the register.
    always_ff @(posedge i_clk) begin
        r_tsq <= ggedge_pkg::TSQ_W'(r_cfg_thresh) * ggedge_pkg::TSQ_W'(r_cfg_thresh);
    end

    // ---------------------------------------------------------- ready chain
    assign w_rdy5 = !r_v5 || (i_m_axis_tready && o_m_axis_tlast);
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------- position of the request
    always_comb begin
        w_pos.col             = r_col;
        w_pos.flags.last_col  = (r_col == r_w_last);
        w_pos.flags.last_row  = (r_row == r_h_last);
        w_pos.flags.has_above = (r_row != '0);
        w_pos.flags.interior  = (r_row[ggedge_pkg::ROW_W-1:1] != '0) && (r_col != '0)
                                && !w_pos.flags.last_col;
        if (w_pos.flags.last_col) begin
            n_col = '0;
            n_row = w_pos.flags.last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // A size write restarts the frame; user writes must come only while the block idles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= ggedge_pkg::RST_IMAGE_WIDTH;
            r_cfg_height <= ggedge_pkg::RST_IMAGE_HEIGHT;
            r_cfg_thresh <= ggedge_pkg::RST_EDGE_THRESHOLD;
            r_w_last     <= ggedge_pkg::col_last(ggedge_pkg::RST_IMAGE_WIDTH);
            r_h_last     <= ggedge_pkg::row_last(ggedge_pkg::RST_IMAGE_HEIGHT);
            r_col        <= '0;
            r_row        <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                ggedge_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_width <= w_cfg_val;
                    r_w_last    <= ggedge_pkg::col_last(w_cfg_val);
                    r_col       <= '0;
                    r_row       <= '0;
                end
                ggedge_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_height <= w_cfg_val;
                    r_h_last     <= ggedge_pkg::row_last(w_cfg_val);
                    r_col        <= '0;
                    r_row        <= '0;
                end
                ggedge_pkg::REG_EDGE_THRESHOLD: begin
                    r_cfg_thresh <= w_cfg_val;
                end
                default: begin
                end
            endcase
        end else if (w_in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ----------------------------------------------------------- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            // A first-row pixel of a taller frame gives no result and ends here.
            if (w_rdy5) begin
                r_v5 <= r_v4 && (r_flags4.has_above || r_flags4.last_row);
            end
        end
    end

    // --------------------------------------------------- stage 1: weighted sum
    assign w_sum = ggedge_pkg::SUM_W'(i_s_axis_tdata[7:0])   * ggedge_pkg::W_RED
                 + ggedge_pkg::SUM_W'(i_s_axis_tdata[15:8])  * ggedge_pkg::W_GREEN
                 + ggedge_pkg::SUM_W'(i_s_axis_tdata[23:16]) * ggedge_pkg::W_BLUE;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sum1 <= w_sum;
            r_pos1 <= w_pos;
        end
    end

    // ----------------------------------------- stage 2: divide by 100 as a product
    assign w_prod = ggedge_pkg::PROD_W'(r_sum1) * ggedge_pkg::PROD_W'(ggedge_pkg::GRAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdy2) begin
            r_gray2 <= w_prod[ggedge_pkg::GRAY_SHIFT +: ggedge_pkg::PIX_W];
            r_pos2  <= r_pos1;
        end
    end

    // ----------------------------------------------------- stage 3: line store
    ggedge_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_v2 && w_rdy3),
        .i_gray  (r_gray2),
        .i_pos   (r_pos2),
        .o_grad  (w_grad3)
    );

    // ------------------------------------------------ stage 4: squared gradient
    assign w_dx_sq = w_grad3.dx * w_grad3.dx;
    assign w_dy_sq = w_grad3.dy * w_grad3.dy;

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_rdy4) begin
            r_mag4   <= ggedge_pkg::MAG_W'(w_dx_sq[ggedge_pkg::SQ_W-1:0])
                      + ggedge_pkg::MAG_W'(w_dy_sq[ggedge_pkg::SQ_W-1:0]);
            r_up4    <= w_grad3.up;
            r_gray4  <= w_grad3.gray;
            r_flags4 <= w_grad3.flags;
        end
    end

    // ------------------------------------------------ stage 5: result pair
    assign w_edge4 = {{(ggedge_pkg::TSQ_W-ggedge_pkg::MAGX_W){1'b0}}, r_mag4,
                      {ggedge_pkg::MAG_SHIFT{1'b0}}} > r_tsq;
    assign w_level_a4 = !r_flags4.interior ? r_up4 :
                        w_edge4 ? ggedge_pkg::LEVEL_BLACK : ggedge_pkg::LEVEL_WHITE;

    always_ff @(posedge i_clk) begin
        if (r_v4 && w_rdy5) begin
            r_a_level5  <= w_level_a4;
            r_a_int5    <= r_flags4.interior;
            r_b_level5  <= r_gray4;
            r_b_valid5  <= r_flags4.last_row;
            r_last_col5 <= r_flags4.last_col;
        end
    end

    // r_sel5 picks the pixel's own border result after the one from the row above.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel5 <= 1'b0;
        end else if (r_v4 && w_rdy5) begin
            r_sel5 <= !r_flags4.has_above;
        end else if (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) begin
            r_sel5 <= 1'b1;
        end
    end

    assign o_m_axis_tvalid   = r_v5;
    assign o_m_axis_tdata    = r_sel5 ? r_b_level5 : r_a_level5;
    assign o_m_axis_tuser[0] = !r_sel5 && r_a_int5;
    assign o_m_axis_tuser[1] = r_sel5 && r_last_col5;
    assign o_m_axis_tlast    = r_sel5 || !r_b_valid5;

endmodule

[src/ggedge_checker.sv]
// Port-level checks of the gray gradient edge block, bound to its top level.
// Depends on gray_gradient_edge_threshold_defines.svh.
`include "gray_gradient_edge_threshold_defines.svh"

module ggedge_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // A result that waits is held unchanged.
    `GGEDGE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))

    // The end of the frame is a border pixel and closes its request.
    `GGEDGE_ASSERT_SAME(a_frame_end, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tlast && !o_m_axis_tuser[0])

    // A thresholded pixel is either black or white.
    `GGEDGE_ASSERT_SAME(a_binary_level, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == 8'h00 || o_m_axis_tdata == 8'hFF)

    // The first of two results is followed at once by the border result.
    `GGEDGE_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid && o_m_axis_tlast && !o_m_axis_tuser[0])

    // Reset empties the result stage.
    `GGEDGE_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, !o_m_axis_tvalid)

endmodule

bind gray_gradient_edge_threshold ggedge_checker u_ggedge_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[tb/sv/tb_gray_gradient_edge_threshold.sv]
// Self-checking testbench for the gray gradient edge block: stream driver,
// register writes with read-back, and a scoreboard that predicts every result.
// Depends on ggedge_pkg and on the gray_gradient_edge_threshold RTL.

// One predicted output pixel, field for field as the block emits it.
typedef struct {
    logic [7:0] level;
    logic       interior;
    logic       last_in_run;
    logic       frame_done;
} t_edge_pixel;

// Keeps its own copy of the registers, the two line stores and the raster
// position, and queues the output pixels that each accepted request causes.
class edge_image_scoreboard;
    logic [11:0]   width_reg;
    logic [11:0]   height_reg;
    logic [11:0]   thresh_reg;
    bit [7:0]      row_above [ggedge_pkg::MAX_WIDTH];
    bit [7:0]      row_above2 [ggedge_pkg::MAX_WIDTH];
    bit [7:0]      above_left;
    int unsigned   col;
    int unsigned   row;
    t_edge_pixel   awaited[$];
    int unsigned   errors;
    int unsigned   results_seen;

    function new();
        width_reg    = ggedge_pkg::RST_IMAGE_WIDTH;
        height_reg   = ggedge_pkg::RST_IMAGE_HEIGHT;
        thresh_reg   = ggedge_pkg::RST_EDGE_THRESHOLD;
        above_left   = '0;
        col          = 0;
        row          = 0;
        errors       = 0;
        results_seen = 0;
    endfunction

    task report(input string what);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH %0d: %s", errors, what);
        end
    endtask

    // A size write starts a new frame; the threshold applies from the next pixel.
    function void write_reg(input ggedge_pkg::t_reg_idx idx, input logic [11:0] v);
        case (idx)
            ggedge_pkg::REG_IMAGE_WIDTH: begin
                width_reg = v;
                col = 0;
                row = 0;
            end
            ggedge_pkg::REG_IMAGE_HEIGHT: begin
                height_reg = v;
                col = 0;
                row = 0;
            end
            ggedge_pkg::REG_EDGE_THRESHOLD: begin
                thresh_reg = v;
            end
            default: begin
            end
        endcase
    endfunction

    function int unsigned fit_size(input logic [11:0] v, input int unsigned top);
        if (v == 0) begin
            return 1;
        end
        if (v > top) begin
            return top;
        end
        return v;
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction

    // Pixel packed as {blue, green, red}.
    function void take_pixel(input logic [23:0] px);
        int unsigned w, h, x, y, gray, mag, tt;
        int          dx, dy;
        bit          last_row, last_col, interior;
        bit [7:0]    up;
        t_edge_pixel e;
        w = fit_size(width_reg, ggedge_pkg::MAX_WIDTH);
        h = fit_size(height_reg, ggedge_pkg::MAX_HEIGHT);
        x = (col >= w) ? 0 : col;
        y = (row >= h) ? 0 : row;
        last_row = (y == h - 1);
        last_col = (x == w - 1);
        gray = (30 * int'(px[7:0]) + 59 * int'(px[15:8]) + 11 * int'(px[23:16])) / 100;

        // Every row but the first releases the pixel one row up.
        if (y >= 1) begin
            up = row_above[x];
            interior = (y >= 2) && (x >= 1) && !last_col;
            e.level = up;
            if (interior) begin
                dx = int'(row_above[x + 1]) - int'(above_left);
                dy = int'(gray) - int'(row_above2[x]);
                mag = 64 * (dx * dx + dy * dy);
                tt = int'(thresh_reg) * int'(thresh_reg);
                e.level = (mag > tt) ? ggedge_pkg::LEVEL_BLACK : ggedge_pkg::LEVEL_WHITE;
            end
            e.interior = interior;
            e.last_in_run = !last_row;
            e.frame_done = 1'b0;
            awaited.push_back(e);
            above_left = up;
        end
        // The last row also emits itself as a border gray.
        if (last_row) begin
            e.level = gray[7:0];
            e.interior = 1'b0;
            e.last_in_run = 1'b1;
            e.frame_done = last_col;
            awaited.push_back(e);
        end

        row_above2[x] = row_above[x];
        row_above[x] = gray[7:0];
        if (last_col) begin
            col = 0;
            row = last_row ? 0 : y + 1;
        end else begin
            col = x + 1;
            row = y;
        end
    endfunction

    // tuser holds is_interior in bit 0 and frame_done in bit 1.
    task check_pixel_out(input logic [7:0] level, input logic [1:0] user, input logic last);
        t_edge_pixel e;
        results_seen++;
        if (awaited.size() == 0) begin
            report($sformatf("result %0d (level %0d) with nothing outstanding",
                             results_seen, level));
        end else begin
            e = awaited.pop_front();
            if (level !== e.level) begin
                report($sformatf("result %0d level %0d, predicted %0d",
                                 results_seen, level, e.level));
            end
            if (user[0] !== e.interior) begin
                report($sformatf("result %0d is_interior %b, predicted %b",
                                 results_seen, user[0], e.interior));
            end
            if (last !== e.last_in_run) begin
                report($sformatf("result %0d last_in_run %b, predicted %b",
                                 results_seen, last, e.last_in_run));
            end
            if (user[1] !== e.frame_done) begin
                report($sformatf("result %0d frame_done %b, predicted %b",
                                 results_seen, user[1], e.frame_done));
            end
        end
    endtask
endclass

module tb_gray_gradient_edge_threshold;
    import ggedge_pkg::*;

    // Generous bound on the whole run; the slowest legal run stays far below it.
    localparam int unsigned RUN_LIMIT      = 600_000;
    // Cycles allowed after the last predicted result, well above the pipeline depth.
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned RANDOM_PHASES  = 14;
    localparam int unsigned HEAVY_IDLE_PCT = 71;
    localparam int unsigned LIGHT_IDLE_PCT = 16;
    localparam int unsigned MAX_PHASE_PIX  = 160;
    localparam int unsigned WIDE_ROW_PIX   = 320;
    // Address 12 decodes to no register; a write there must change nothing.
    localparam t_reg_idx    REG_UNMAPPED   = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [23:0]           s_tdata = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;
    logic [1:0]            o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_idle_mode            idle_mode = IDLE_NONE;
    int unsigned           cycles = 0;
    edge_image_scoreboard  sb;

    always #5 i_clk = ~i_clk;

    gray_gradient_edge_threshold DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Chance in a hundred that the sender holds back a request this cycle.
    function automatic int unsigned send_gap_pct();
        case (idle_mode)
            IDLE_SENDER: return HEAVY_IDLE_PCT;
            IDLE_BOTH:   return LIGHT_IDLE_PCT;
            default:     return 0;
        endcase
    endfunction

    // Chance in a hundred that the result side stalls this cycle.
    function automatic int unsigned stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return HEAVY_IDLE_PCT;
            IDLE_BOTH:     return LIGHT_IDLE_PCT;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return {b, g, r};
    endfunction

    // A smooth pixel sits within a few steps of the phase's base gray, so the
    // gradients land near small thresholds; the rest are fully random.
    function automatic logic [23:0] make_pixel(input int unsigned smooth_pct,
                                               input int unsigned base);
        logic [7:0] r, g, b;
        if ($urandom_range(99) < smooth_pct) begin
            r = 8'(base - 3 + $urandom_range(6));
            g = 8'(base - 3 + $urandom_range(6));
            b = 8'(base - 3 + $urandom_range(6));
            return rgb(r, g, b);
        end
        return 24'($urandom);
    endfunction

    // Results are sampled at the edge with the values settled before it, and
    // the result-side ready is redrawn every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_pixel_out(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
        m_tready <= ($urandom_range(99) >= stall_pct());
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("gray_gradient_edge_threshold regression: fail");
            $finish;
        end
    end

    // One pixel request. Valid goes low only while the sender idles, so it is
    // never dropped and raised again within the same step.
    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < send_gap_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.take_pixel(px);
    endtask

    // Stop sending, let every predicted result arrive, then give the block
    // time to finish work on requests that cause no result (first-row pixels).
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write (setup, then access), followed by a read-back for mapped
    // registers. Bits above the 12-bit field carry random junk on the write.
    // The port idles at the end, before the next transfer.
    task automatic reg_write(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        logic [APB_DATA_W-1:0] junk;
        logic [APB_DATA_W-1:0] readback;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[APB_DATA_W-1:CFG_W], v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        if (idx != REG_UNMAPPED) begin
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            readback = prdata;
            if (readback !== APB_DATA_W'(v)) begin
                sb.report($sformatf("register %0d reads %0h, written %0h",
                                    idx, readback, v));
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned frame_w;
        int unsigned frame_h;
        int unsigned thresh;
        int unsigned count;
        int unsigned area;
        int unsigned smooth;
        int unsigned base;
        bit          new_sizes;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. A write to the unmapped address must be
        // ignored by the block.
        reg_write(REG_UNMAPPED, 12'hABC);

        // 3x3 frame with full-swing channels and a zero threshold: the single
        // interior pixel sees a strong gradient and turns black. The frame
        // covers first row, last row, frame end and the counter wrap.
        reg_write(REG_IMAGE_WIDTH, 12'd3);
        reg_write(REG_IMAGE_HEIGHT, 12'd3);
        reg_write(REG_EDGE_THRESHOLD, 12'd0);
        send_pixel(rgb(8'd0, 8'd0, 8'd0));
        send_pixel(rgb(8'd255, 8'd255, 8'd255));
        send_pixel(rgb(8'd0, 8'd0, 8'd0));
        send_pixel(rgb(8'd255, 8'd0, 8'd0));
        send_pixel(rgb(8'd0, 8'd255, 8'd0));
        send_pixel(rgb(8'd0, 8'd0, 8'd255));
        send_pixel(rgb(8'd255, 8'd255, 8'd255));
        send_pixel(rgb(8'd0, 8'd0, 8'd0));
        send_pixel(rgb(8'd255, 8'd255, 8'd255));
        finish_phase();

        // Threshold change only, so the same frame size goes on. A one-step
        // horizontal difference gives 64*1 against 8*8: exactly equal, which
        // must stay white.
        reg_write(REG_EDGE_THRESHOLD, 12'd8);
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd101, 8'd101, 8'd101));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        send_pixel(rgb(8'd100, 8'd100, 8'd100));
        finish_phase();

        // Zero sizes count as one: every pixel is a whole frame by itself.
        reg_write(REG_IMAGE_WIDTH, 12'd0);
        reg_write(REG_IMAGE_HEIGHT, 12'd0);
        send_pixel(rgb(8'd255, 8'd0, 8'd255));
        send_pixel(rgb(8'd0, 8'd255, 8'd0));
        finish_phase();

        // Random part. The idling pattern rotates over the phases. Most
        // phases use small frames and send more than one frame's worth of pixels;
        // two phases take the size extremes, and a few keep the previous
        // size so that only the threshold changes.
        frame_w = 3;
        frame_h = 3;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_mode = t_idle_mode'(p % 4);
            base = $urandom_range(3, 252);
            smooth = $urandom_range(100);
            new_sizes = 1'b1;
            if (p == 3) begin
                // Oversized width clamps to the full line store; one row, so
                // each pixel is its own border result.
                frame_w = 4095;
                frame_h = 0;
                count = WIDE_ROW_PIX;
            end else if (p == 7) begin
                // One column and a clamped height that is never reached.
                frame_w = 1;
                frame_h = 4095;
                count = 60;
            end else begin
                if (p % 5 == 2) begin
                    new_sizes = 1'b0;
                end else begin
                    frame_w = $urandom_range(1, 12);
                    frame_h = $urandom_range(1, 8);
                end
                area = frame_w * frame_h;
                count = area + $urandom_range(2 * area) + $urandom_range(8, 30);
                if (count > MAX_PHASE_PIX) begin
                    count = MAX_PHASE_PIX;
                end
            end
            if (p == 0) begin
                thresh = 4095;
            end else if (p == 1) begin
                thresh = 0;
            end else if ($urandom_range(1) == 0) begin
                thresh = $urandom_range(200);
            end else begin
                thresh = $urandom_range(4095);
            end

            if (new_sizes) begin
                reg_write(REG_IMAGE_WIDTH, CFG_W'(frame_w));
                reg_write(REG_IMAGE_HEIGHT, CFG_W'(frame_h));
            end
            reg_write(REG_EDGE_THRESHOLD, CFG_W'(thresh));
            repeat (count) send_pixel(make_pixel(smooth, base));
            finish_phase();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("gray_gradient_edge_threshold regression: pass");
        end else begin
            $display("gray_gradient_edge_threshold regression: fail");
        end
        $finish;
    end

endmodule
